// File: rtl/scit_pkg.sv
// Package for the swept circle impact time block: widths, constants and
// the structs that travel between the front end, the queue and the back end.
// Has no dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package scit_pkg;

  // Field widths of the input and result words.
  localparam int unsigned PosW    = 20;
  localparam int unsigned VelW    = 22;
  localparam int unsigned RadW    = 8;
  localparam int unsigned StepW   = 16;
  localparam int unsigned FracW   = 17;
  localparam int unsigned SumRadW = RadW + 1;

  // Displacement is velocity times step, exact.
  localparam int unsigned DispW = VelW + StepW;
  // Position is scaled by 2^16 to share the 2^-24 length unit.
  localparam int unsigned ScaleSh = 16;
  // The summed radius squared is scaled by 2^48.
  localparam int unsigned RadSh = 48;

  // Wide multiplier operand and product, split in limbs.
  localparam int unsigned OpW    = 76;
  localparam int unsigned ProdW  = 2 * OpW;
  localparam int unsigned LimbW  = 26;
  localparam int unsigned Limbs  = 3;
  localparam int unsigned MulLat = 3;

  // Quadratic terms.
  localparam int unsigned AW    = 76;
  localparam int unsigned DpW   = 75;
  localparam int unsigned CW    = 74;
  localparam int unsigned DiscW = 152;
  localparam int unsigned RootW = DiscW / 2;
  localparam int unsigned RemW  = RootW + 3;
  localparam int unsigned NW    = 78;
  localparam int unsigned DivW  = AW + 1;

  localparam int unsigned SqrtSteps = DiscW / 2;
  localparam int unsigned DivSteps  = FracW;

  // Queue between front and back end.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [RadW-1:0]  BallRadiusRst = 8'd20;
  localparam logic [FracW-1:0] FracOne       = FracW'(1) << (FracW - 1);

  // Word handed from the front end to the back end.
  typedef struct packed {
    logic signed [DispW-1:0] dx;
    logic signed [DispW-1:0] dy;
    logic signed [PosW-1:0]  px;
    logic signed [PosW-1:0]  py;
    logic [SumRadW-1:0]      rad;
    logic                    zero;
  } item_t;

  // Magnitudes and signs that feed the first multiplier bank.
  typedef struct packed {
    logic               vld;
    logic [DispW-1:0]   dxm;
    logic [DispW-1:0]   dym;
    logic [PosW-1:0]    pxm;
    logic [PosW-1:0]    pym;
    logic               sdp0;
    logic               sdp1;
    logic [SumRadW-1:0] rad;
    logic               zero;
  } v0_t;

  // Side data that rides along the first multiplier bank.
  typedef struct packed {
    logic               vld;
    logic               sdp0;
    logic               sdp1;
    logic [SumRadW-1:0] rad;
    logic               zero;
  } side1_t;

  // The quadratic coefficients a, dp and c.
  typedef struct packed {
    logic                  vld;
    logic [AW-1:0]         a;
    logic signed [DpW-1:0] dp;
    logic signed [CW-1:0]  c;
    logic                  zero;
  } coef_t;

  // Coefficients with magnitudes for the second multiplier bank.
  typedef struct packed {
    logic                  vld;
    logic [AW-1:0]         a;
    logic signed [DpW-1:0] dp;
    logic [DpW-1:0]        dpm;
    logic [CW-1:0]         cm;
    logic                  sc;
    logic                  zero;
  } v2_t;

  // Side data that rides along the second multiplier bank.
  typedef struct packed {
    logic                  vld;
    logic [AW-1:0]         a;
    logic signed [DpW-1:0] dp;
    logic                  sc;
    logic                  zero;
  } side2_t;

  // One stage of the square root recurrence.
  typedef struct packed {
    logic                  vld;
    logic [AW-1:0]         a;
    logic signed [DpW-1:0] dp;
    logic                  skip;
    logic [RemW-1:0]       rem;
    logic [RootW-1:0]      root;
    logic [DiscW-1:0]      rad;
  } sq_t;

  // One stage of the fraction divider.
  typedef struct packed {
    logic             vld;
    logic [AW-1:0]    a;
    logic             hit;
    logic [DivW-1:0]  r;
    logic [FracW-1:0] q;
  } dv_t;

endpackage
`default_nettype wire

// File: rtl/scit_in_if.sv
// Input channel of the swept circle impact time block.
// Carries valid, ready and one query word; widths come from scit_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface scit_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [scit_pkg::PosW-1:0]     rel_pos_x;
  logic signed [scit_pkg::PosW-1:0]     rel_pos_y;
  logic        [scit_pkg::RadW-1:0]     other_radius;
  logic signed [scit_pkg::VelW-1:0]     rel_vel_x;
  logic signed [scit_pkg::VelW-1:0]     rel_vel_y;
  logic        [scit_pkg::StepW-1:0]    step_time;

  modport source (
    output valid, rel_pos_x, rel_pos_y, other_radius, rel_vel_x, rel_vel_y, step_time,
    input  ready
  );
  modport sink (
    input  valid, rel_pos_x, rel_pos_y, other_radius, rel_vel_x, rel_vel_y, step_time,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/scit_out_if.sv
// Result channel of the swept circle impact time block.
// Carries valid, ready and one result word; widths come from scit_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface scit_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [scit_pkg::FracW-1:0]    impact_fraction;

  modport source (output valid, hit, impact_fraction, input ready);
  modport sink   (input valid, hit, impact_fraction, output ready);
endinterface
`default_nettype wire

// File: rtl/scit_fifo.sv
// Short queue of classified words between the front end and the back end.
// Depends on scit_pkg for the word type and the depth.
`timescale 1ns / 1ps
`default_nettype none
module scit_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  scit_pkg::item_t      item_i,
  input  wire logic            pop_i,
  output scit_pkg::item_t      item_o,
  output logic                 full_o,
  output logic                 empty_o
);

  scit_pkg::item_t                mem_q [scit_pkg::QDepth];
  logic [scit_pkg::QPtrW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [scit_pkg::QPtrW:0]       cnt_q, cnt_d;

  // Flags and the head word.
  assign full_o  = (cnt_q == (scit_pkg::QPtrW + 1)'(scit_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rp_q];

  // Pointer and fill count updates.
  always_comb begin
    wp_d  = push_i ? wp_q + 1'b1 : wp_q;
    rp_d  = pop_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage is written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("word pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("word popped from an empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (scit_pkg::QPtrW + 1)'(scit_pkg::QDepth))
    else $error("queue fill count beyond depth");
`endif

endmodule
`default_nettype wire

// File: rtl/scit_mul.sv
// Pipelined unsigned wide multiplier built from narrow limb products.
// Three register stages: limb products, column sums, final sum. Uses scit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scit_mul (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [scit_pkg::OpW-1:0]   a_i,
  input  wire logic [scit_pkg::OpW-1:0]   b_i,
  output logic      [scit_pkg::ProdW-1:0] p_o
);

  localparam int unsigned PadW = scit_pkg::Limbs * scit_pkg::LimbW;
  localparam int unsigned PpW  = 2 * scit_pkg::LimbW;
  localparam int unsigned GrpN = 2 * scit_pkg::Limbs - 1;
  localparam int unsigned GrpW = PpW + 2;
  localparam int unsigned AccW = 2 * PadW + 2;

  logic [PadW-1:0]             ax, bx;
  logic [scit_pkg::LimbW-1:0]  al [scit_pkg::Limbs];
  logic [scit_pkg::LimbW-1:0]  bl [scit_pkg::Limbs];
  logic [PpW-1:0]              pp_q [scit_pkg::Limbs][scit_pkg::Limbs];
  logic [GrpW-1:0]             grp_d [GrpN];
  logic [GrpW-1:0]             grp_q [GrpN];
  logic [AccW-1:0]             acc;
  logic [scit_pkg::ProdW-1:0]  p_q;

  assign ax = PadW'(a_i);
  assign bx = PadW'(b_i);

  // Split the operands into limbs.
  always_comb begin
    for (int i = 0; i < scit_pkg::Limbs; i++) begin
      al[i] = ax[i*scit_pkg::LimbW +: scit_pkg::LimbW];
      bl[i] = bx[i*scit_pkg::LimbW +: scit_pkg::LimbW];
    end
  end

  // Column sums of the limb products.
  always_comb begin
    for (int k = 0; k < GrpN; k++) begin
      grp_d[k] = '0;
    end
    for (int i = 0; i < scit_pkg::Limbs; i++) begin
      for (int j = 0; j < scit_pkg::Limbs; j++) begin
        grp_d[i+j] = grp_d[i+j] + GrpW'(pp_q[i][j]);
      end
    end
  end

  // Final weighted sum of the columns.
  always_comb begin
    acc = '0;
    for (int k = 0; k < GrpN; k++) begin
      acc = acc + (AccW'(grp_q[k]) << (k * scit_pkg::LimbW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < scit_pkg::Limbs; i++) begin
        for (int j = 0; j < scit_pkg::Limbs; j++) begin
          pp_q[i][j] <= PpW'(al[i]) * PpW'(bl[j]);
        end
      end
      for (int k = 0; k < GrpN; k++) begin
        grp_q[k] <= grp_d[k];
      end
      p_q <= acc[scit_pkg::ProdW-1:0];
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: rtl/scit_front.sv
// Front end: takes query words, forms the displacement and summed radius,
// flags zero displacement and pushes the word into the queue. Uses scit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scit_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  scit_in_if.sink                       in_i,
  input  wire logic [scit_pkg::RadW-1:0] ball_radius_i,
  input  wire logic                     full_i,
  output logic                          push_o,
  output scit_pkg::item_t               item_o
);

  logic                                 f_vld_q;
  scit_pkg::item_t                      f_item_q, f_item_d;
  logic signed [scit_pkg::DispW-1:0]    vx_ext, vy_ext, st_ext;

  // A word is taken whenever the holding register is free or drains this cycle.
  assign in_i.ready = !f_vld_q || !full_i;
  assign push_o     = f_vld_q && !full_i;
  assign item_o     = f_item_q;

  // Displacement, summed radius and the zero displacement flag.
  always_comb begin
    vx_ext         = scit_pkg::DispW'(in_i.rel_vel_x);
    vy_ext         = scit_pkg::DispW'(in_i.rel_vel_y);
    st_ext         = scit_pkg::DispW'(in_i.step_time);
    f_item_d.dx    = vx_ext * st_ext;
    f_item_d.dy    = vy_ext * st_ext;
    f_item_d.px    = in_i.rel_pos_x;
    f_item_d.py    = in_i.rel_pos_y;
    f_item_d.rad   = scit_pkg::SumRadW'(in_i.other_radius)
                   + scit_pkg::SumRadW'(ball_radius_i);
    f_item_d.zero  = (f_item_d.dx == '0) && (f_item_d.dy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      f_vld_q <= 1'b1;
    end else if (push_o) begin
      f_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      f_item_q <= f_item_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/scit_back.sv
// Back end: quadratic coefficients, discriminant, square root recurrence and
// fraction divider as one stallable pipeline. Uses scit_pkg, scit_mul, scit_out_if.
`timescale 1ns / 1ps
`default_nettype none
module scit_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        empty_i,
  input  scit_pkg::item_t  item_i,
  output logic             pop_o,
  scit_out_if.source       out_o
);

  localparam int unsigned MulN = 8;

  logic                         en;
  scit_pkg::v0_t                v0_q, v0_d;
  scit_pkg::side1_t             sd1_q [scit_pkg::MulLat];
  scit_pkg::coef_t              v1_q, v1_d;
  scit_pkg::v2_t                v2_q, v2_d;
  scit_pkg::side2_t             sd2_q [scit_pkg::MulLat];
  scit_pkg::sq_t                sq_q [scit_pkg::SqrtSteps+1];
  scit_pkg::sq_t                sq_d [scit_pkg::SqrtSteps+1];
  scit_pkg::dv_t                dv_q [scit_pkg::DivSteps+1];
  scit_pkg::dv_t                dv_d [scit_pkg::DivSteps+1];
  logic [scit_pkg::OpW-1:0]     mul_a [MulN];
  logic [scit_pkg::OpW-1:0]     mul_b [MulN];
  logic [scit_pkg::ProdW-1:0]   mul_p [MulN];
  logic [2*scit_pkg::SumRadW-1:0] rr;
  logic signed [scit_pkg::DpW-1:0] t0, t1;
  logic signed [scit_pkg::NW-1:0]  n_val;

  // The whole pipeline moves unless a result waits at the output.
  assign en    = !dv_q[scit_pkg::DivSteps].vld || out_o.ready;
  assign pop_o = en && !empty_i;

  // Entry stage: magnitudes and product signs.
  always_comb begin
    v0_d.vld  = !empty_i;
    v0_d.dxm  = item_i.dx[scit_pkg::DispW-1] ? scit_pkg::DispW'(-item_i.dx)
                                             : scit_pkg::DispW'(item_i.dx);
    v0_d.dym  = item_i.dy[scit_pkg::DispW-1] ? scit_pkg::DispW'(-item_i.dy)
                                             : scit_pkg::DispW'(item_i.dy);
    v0_d.pxm  = item_i.px[scit_pkg::PosW-1] ? scit_pkg::PosW'(-item_i.px)
                                            : scit_pkg::PosW'(item_i.px);
    v0_d.pym  = item_i.py[scit_pkg::PosW-1] ? scit_pkg::PosW'(-item_i.py)
                                            : scit_pkg::PosW'(item_i.py);
    v0_d.sdp0 = item_i.dx[scit_pkg::DispW-1] ^ item_i.px[scit_pkg::PosW-1];
    v0_d.sdp1 = item_i.dy[scit_pkg::DispW-1] ^ item_i.py[scit_pkg::PosW-1];
    v0_d.rad  = item_i.rad;
    v0_d.zero = item_i.zero;
  end

  // Multiplier operands: first bank for a, dp and |p|^2, second for disc.
  always_comb begin
    mul_a[0] = scit_pkg::OpW'(v0_q.dxm);
    mul_b[0] = scit_pkg::OpW'(v0_q.dxm);
    mul_a[1] = scit_pkg::OpW'(v0_q.dym);
    mul_b[1] = scit_pkg::OpW'(v0_q.dym);
    mul_a[2] = scit_pkg::OpW'(v0_q.dxm);
    mul_b[2] = scit_pkg::OpW'({v0_q.pxm, {scit_pkg::ScaleSh{1'b0}}});
    mul_a[3] = scit_pkg::OpW'(v0_q.dym);
    mul_b[3] = scit_pkg::OpW'({v0_q.pym, {scit_pkg::ScaleSh{1'b0}}});
    mul_a[4] = scit_pkg::OpW'({v0_q.pxm, {scit_pkg::ScaleSh{1'b0}}});
    mul_b[4] = scit_pkg::OpW'({v0_q.pxm, {scit_pkg::ScaleSh{1'b0}}});
    mul_a[5] = scit_pkg::OpW'({v0_q.pym, {scit_pkg::ScaleSh{1'b0}}});
    mul_b[5] = scit_pkg::OpW'({v0_q.pym, {scit_pkg::ScaleSh{1'b0}}});
    mul_a[6] = scit_pkg::OpW'(v2_q.dpm);
    mul_b[6] = scit_pkg::OpW'(v2_q.dpm);
    mul_a[7] = scit_pkg::OpW'(v2_q.a);
    mul_b[7] = scit_pkg::OpW'(v2_q.cm);
  end

  for (genvar g = 0; g < MulN; g++) begin : g_mul
    scit_mul u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (mul_a[g]),
      .b_i   (mul_b[g]),
      .p_o   (mul_p[g])
    );
  end

  // Coefficients a, dp and c from the first bank.
  always_comb begin
    rr        = scit_pkg::SumRadW'(sd1_q[scit_pkg::MulLat-1].rad)
              * scit_pkg::SumRadW'(sd1_q[scit_pkg::MulLat-1].rad);
    t0        = scit_pkg::DpW'(mul_p[2]);
    t1        = scit_pkg::DpW'(mul_p[3]);
    v1_d.vld  = sd1_q[scit_pkg::MulLat-1].vld;
    v1_d.zero = sd1_q[scit_pkg::MulLat-1].zero;
    v1_d.a    = scit_pkg::AW'(mul_p[0]) + scit_pkg::AW'(mul_p[1]);
    v1_d.dp   = (sd1_q[scit_pkg::MulLat-1].sdp0 ? -t0 : t0)
              + (sd1_q[scit_pkg::MulLat-1].sdp1 ? -t1 : t1);
    v1_d.c    = scit_pkg::CW'(mul_p[4]) + scit_pkg::CW'(mul_p[5])
              - (scit_pkg::CW'(rr) << scit_pkg::RadSh);
  end

  // Magnitudes of dp and c for the second bank.
  always_comb begin
    v2_d.vld  = v1_q.vld;
    v2_d.a    = v1_q.a;
    v2_d.dp   = v1_q.dp;
    v2_d.zero = v1_q.zero;
    v2_d.dpm  = v1_q.dp[scit_pkg::DpW-1] ? scit_pkg::DpW'(-v1_q.dp)
                                         : scit_pkg::DpW'(v1_q.dp);
    v2_d.cm   = v1_q.c[scit_pkg::CW-1] ? scit_pkg::CW'(-v1_q.c)
                                       : scit_pkg::CW'(v1_q.c);
    v2_d.sc   = v1_q.c[scit_pkg::CW-1];
  end

  // Discriminant dp^2 - a*c opens the square root recurrence.
  always_comb begin
    sq_d[0].vld  = sd2_q[scit_pkg::MulLat-1].vld;
    sq_d[0].a    = sd2_q[scit_pkg::MulLat-1].a;
    sq_d[0].dp   = sd2_q[scit_pkg::MulLat-1].dp;
    sq_d[0].rad  = sd2_q[scit_pkg::MulLat-1].sc ? mul_p[6] + mul_p[7]
                                                : mul_p[6] - mul_p[7];
    sq_d[0].skip = sd2_q[scit_pkg::MulLat-1].zero || sq_d[0].rad[scit_pkg::DiscW-1];
    sq_d[0].rem  = '0;
    sq_d[0].root = '0;
  end

  // Front stages and the side data delay lines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q.vld <= 1'b0;
      v1_q.vld <= 1'b0;
      v2_q.vld <= 1'b0;
      for (int i = 0; i < scit_pkg::MulLat; i++) begin
        sd1_q[i].vld <= 1'b0;
        sd2_q[i].vld <= 1'b0;
      end
    end else if (en) begin
      v0_q          <= v0_d;
      v1_q          <= v1_d;
      v2_q          <= v2_d;
      sd1_q[0].vld  <= v0_q.vld;
      sd1_q[0].sdp0 <= v0_q.sdp0;
      sd1_q[0].sdp1 <= v0_q.sdp1;
      sd1_q[0].rad  <= v0_q.rad;
      sd1_q[0].zero <= v0_q.zero;
      sd2_q[0].vld  <= v2_q.vld;
      sd2_q[0].a    <= v2_q.a;
      sd2_q[0].dp   <= v2_q.dp;
      sd2_q[0].sc   <= v2_q.sc;
      sd2_q[0].zero <= v2_q.zero;
      for (int i = 1; i < scit_pkg::MulLat; i++) begin
        sd1_q[i] <= sd1_q[i-1];
        sd2_q[i] <= sd2_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0].vld <= 1'b0;
    end else if (en) begin
      sq_q[0] <= sq_d[0];
    end
  end

  // Square root, one root bit per stage.
  for (genvar k = 0; k < scit_pkg::SqrtSteps; k++) begin : g_sqrt
    logic [scit_pkg::RemW-1:0] rem2, trial;

    always_comb begin
      rem2  = {sq_q[k].rem[scit_pkg::RemW-3:0], sq_q[k].rad[scit_pkg::DiscW-1 -: 2]};
      trial = scit_pkg::RemW'({sq_q[k].root, 2'b01});
      sq_d[k+1]     = sq_q[k];
      sq_d[k+1].rad = sq_q[k].rad << 2;
      if (rem2 >= trial) begin
        sq_d[k+1].rem  = rem2 - trial;
        sq_d[k+1].root = {sq_q[k].root[scit_pkg::RootW-2:0], 1'b1};
      end else begin
        sq_d[k+1].rem  = rem2;
        sq_d[k+1].root = {sq_q[k].root[scit_pkg::RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[k+1].vld <= 1'b0;
      end else if (en) begin
        sq_q[k+1] <= sq_d[k+1];
      end
    end
  end

  // Numerator -dp - root and the hit test.
  always_comb begin
    n_val = -scit_pkg::NW'(sq_q[scit_pkg::SqrtSteps].dp)
          - scit_pkg::NW'(sq_q[scit_pkg::SqrtSteps].root);
    dv_d[0].vld = sq_q[scit_pkg::SqrtSteps].vld;
    dv_d[0].a   = sq_q[scit_pkg::SqrtSteps].a;
    dv_d[0].r   = n_val[scit_pkg::DivW-1:0];
    dv_d[0].q   = '0;
    dv_d[0].hit = !sq_q[scit_pkg::SqrtSteps].skip && !n_val[scit_pkg::NW-1]
               && (n_val[scit_pkg::DivW-1:0]
                   <= scit_pkg::DivW'(sq_q[scit_pkg::SqrtSteps].a));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0].vld <= 1'b0;
    end else if (en) begin
      dv_q[0] <= dv_d[0];
    end
  end

  // Restoring divider, one fraction bit per stage, the top bit first.
  for (genvar k = 0; k < scit_pkg::DivSteps; k++) begin : g_div
    logic [scit_pkg::DivW-1:0] r2;
    logic                      ge;

    always_comb begin
      r2 = (k == 0) ? dv_q[k].r : (dv_q[k].r << 1);
      ge = (r2 >= scit_pkg::DivW'(dv_q[k].a));
      dv_d[k+1]   = dv_q[k];
      dv_d[k+1].r = ge ? r2 - scit_pkg::DivW'(dv_q[k].a) : r2;
      dv_d[k+1].q = {dv_q[k].q[scit_pkg::FracW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1].vld <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_d[k+1];
      end
    end
  end

  // Result word straight from the last divider stage.
  assign out_o.valid           = dv_q[scit_pkg::DivSteps].vld;
  assign out_o.hit             = dv_q[scit_pkg::DivSteps].hit;
  assign out_o.impact_fraction = dv_q[scit_pkg::DivSteps].hit
                               ? dv_q[scit_pkg::DivSteps].q : '0;

`ifndef SYNTHESIS
  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[scit_pkg::DivSteps].vld && dv_q[scit_pkg::DivSteps].hit
      |-> dv_q[scit_pkg::DivSteps].q <= scit_pkg::FracOne)
    else $error("impact fraction above one step");
  a_zero_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[0].vld && dv_q[0].hit |-> dv_q[0].a != '0)
    else $error("hit reported for zero displacement");
`endif

endmodule
`default_nettype wire

// File: rtl/swept_circle_impact_time.sv
// Top level of the swept circle impact time block: ball radius register,
// front end, queue and back end. Uses scit_pkg, the channel interfaces and submodules.
//
//   Channel   Dir  Handshake      Word
//   in_i      in   valid/ready    position, obstacle radius, velocity, step
//   out_o     out  valid/ready    hit flag, impact fraction
//   cfg       in   cfg_we_i       ball radius
//
// While the output is not stalled, one word per cycle is accepted and one
// result per cycle delivered. The back end holds the 76-stage square root and
// the 17-stage fraction divider behind two banks of pipelined multipliers.
// Reset clears all valid bits and loads a ball radius of 20.
// A stalled output freezes the back end; the queue keeps taking words until full.
`timescale 1ns / 1ps
`default_nettype none
module swept_circle_impact_time (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  scit_in_if.sink                        in_i,
  scit_out_if.source                     out_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [scit_pkg::RadW-1:0] cfg_wdata_i
);

  logic [scit_pkg::RadW-1:0] ball_radius_q;
  logic                      push, pop, full, empty;
  scit_pkg::item_t           push_item, head_item;

  // Ball radius register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ball_radius_q <= scit_pkg::BallRadiusRst;
    end else if (cfg_we_i) begin
      ball_radius_q <= cfg_wdata_i;
    end
  end

  scit_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .ball_radius_i (ball_radius_q),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  scit_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  scit_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .item_i  (head_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
